@@ rtl/core/vlendf_pkg.sv @@
// Package for the varint length deframer.
// Holds field widths, header coding constants, default parameters and the step flag type.
// Depends on nothing; used by every other file of the block but vlendf_ram.
package vlendf_pkg;

   localparam int CHANNEL_W = 4;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] DATA_MASK = 8'h7F;
   localparam logic [BYTE_W-1:0] MORE_FLAG = 8'h80;
   localparam int BITS_PER_GROUP = 7;

   localparam int DEFAULT_CHANNELS = 16;
   localparam int DEFAULT_MAX_HEADER_BYTES = 5;

   typedef struct packed {
      logic emit;
      logic last;
      logic error;
   } step_flags_type;

endpackage

@@ rtl/core/vlendf_req_if.sv @@
// Request channel of the varint length deframer: one tagged byte per request.
// Depends on vlendf_pkg for the field widths.
interface vlendf_req_if;
   logic                             valid;
   logic                             ready;
   logic [vlendf_pkg::CHANNEL_W-1:0] channel;
   logic [vlendf_pkg::BYTE_W-1:0]    in_byte;

   modport source (output valid, output channel, output in_byte, input ready);
   modport sink (input valid, input channel, input in_byte, output ready);
endinterface

@@ rtl/core/vlendf_rsp_if.sv @@
// Response channel of the varint length deframer: payload bytes and header errors.
// Depends on vlendf_pkg for the field widths.
interface vlendf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [vlendf_pkg::CHANNEL_W-1:0] out_channel;
   logic [vlendf_pkg::BYTE_W-1:0]    payload_byte;
   logic                             frame_last;
   logic                             header_error;

   modport source (output valid, output out_channel, output payload_byte,
                   output frame_last, output header_error, input ready);
   modport sink (input valid, input out_channel, input payload_byte,
                 input frame_last, input header_error, output ready);
endinterface

@@ rtl/core/vlendf_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module vlendf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/vlendf_step.sv @@
// Per-channel step: decrements payload count, gathers header bytes, flags overlong headers.
// Depends on vlendf_pkg for header coding constants and the step flag type.
module vlendf_step #(
   parameter int MAX_HEADER_BYTES = vlendf_pkg::DEFAULT_MAX_HEADER_BYTES,
   localparam int AccW = vlendf_pkg::BITS_PER_GROUP * MAX_HEADER_BYTES,
   localparam int CntW = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1,
   localparam int EntW = 2 * AccW + CntW
) (
   input  logic [EntW-1:0]                    cur_entry,
   input  logic [vlendf_pkg::BYTE_W-1:0]      in_byte,
   output logic [EntW-1:0]                    nxt_entry,
   output vlendf_pkg::step_flags_type         flags
);

   localparam int ShW = (AccW > 1) ? $clog2(AccW) : 1;

   logic [AccW-1:0] remaining;
   logic [AccW-1:0] accum;
   logic [CntW-1:0] count;
   logic [CntW-1:0] count_safe;
   logic [CntW:0]   count_inc;
   logic [ShW-1:0]  shift_amt;
   logic [AccW-1:0] remaining_dec;
   logic [AccW-1:0] accum_new;

   assign remaining = cur_entry[EntW-1 -: AccW];
   assign accum     = cur_entry[CntW +: AccW];
   assign count     = cur_entry[CntW-1:0];

   always_comb begin
      count_safe = ({1'b0, count} >= (CntW+1)'(MAX_HEADER_BYTES)) ? '0 : count;
      count_inc = {1'b0, count_safe} + (CntW+1)'(1);
      shift_amt = ShW'(count_safe) * ShW'(vlendf_pkg::BITS_PER_GROUP);
      remaining_dec = remaining - AccW'(1);
      accum_new = accum | (AccW'(in_byte & vlendf_pkg::DATA_MASK) << shift_amt);

      nxt_entry = cur_entry;
      flags = '0;
      priority if (remaining != '0) begin
         nxt_entry = {remaining_dec, accum, count};
         flags.emit = 1'b1;
         flags.last = (remaining_dec == '0);
      end else if ((in_byte & vlendf_pkg::MORE_FLAG) == '0) begin
         nxt_entry = {accum_new, AccW'(0), CntW'(0)};
      end else if (count_inc >= (CntW+1)'(MAX_HEADER_BYTES)) begin
         nxt_entry = '0;
         flags.emit = 1'b1;
         flags.error = 1'b1;
      end else begin
         nxt_entry = {AccW'(0), accum_new, count_inc[CntW-1:0]};
      end
   end

endmodule

@@ rtl/core/varint_length_deframer.sv @@
// Top level of the varint length deframer: channel state memory, bypass and response register.
// Depends on vlendf_pkg, vlendf_req_if, vlendf_rsp_if, vlendf_ram and vlendf_step.
//
//   Port     Direction  Handshake     Carries
//   req_if   in         valid/ready   channel, in_byte
//   rsp_if   out        valid/ready   out_channel, payload_byte, frame_last, header_error
//
// One request is accepted per cycle unless clearing or stalled; any response is registered.
// The rate is set by the single read-modify-write of the channel state memory.
// After reset a clearing pass zeroes each entry of the memory in turn; no request is taken then.
// A response held by a stalled sink stalls the update stage, and with it the request side,
// only while the byte in the update stage gives a response of its own.
module varint_length_deframer #(
   parameter int CHANNELS = vlendf_pkg::DEFAULT_CHANNELS,
   parameter int MAX_HEADER_BYTES = vlendf_pkg::DEFAULT_MAX_HEADER_BYTES
) (
   input logic          clock,
   input logic          reset,
   vlendf_req_if.sink   req_if,
   vlendf_rsp_if.source rsp_if
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AccW = vlendf_pkg::BITS_PER_GROUP * MAX_HEADER_BYTES;
   localparam int CntW = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;
   localparam int EntW = 2 * AccW + CntW;

   logic                             clear_ff, clear_in;
   logic [AW-1:0]                    clear_addr_ff, clear_addr_in;
   logic                             s1_valid_ff, s1_valid_in;
   logic [vlendf_pkg::CHANNEL_W-1:0] s1_chan_ff, s1_chan_in;
   logic [vlendf_pkg::BYTE_W-1:0]    s1_byte_ff, s1_byte_in;
   logic                             byp_valid_ff, byp_valid_in;
   logic [AW-1:0]                    byp_addr_ff, byp_addr_in;
   logic [EntW-1:0]                  byp_data_ff, byp_data_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [vlendf_pkg::CHANNEL_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic [vlendf_pkg::BYTE_W-1:0]    rsp_byte_ff, rsp_byte_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_err_ff, rsp_err_in;

   logic                       s1_go;
   logic                       accept;
   logic                       in_range;
   logic [AW-1:0]              s1_addr;
   logic [EntW-1:0]            ram_rd_data;
   logic [EntW-1:0]            cur_entry;
   logic [EntW-1:0]            nxt_entry;
   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [EntW-1:0]            ram_wr_data;
   vlendf_pkg::step_flags_type flags;

   assign s1_addr = AW'(s1_chan_ff);
   assign cur_entry = (byp_valid_ff && (byp_addr_ff == s1_addr)) ? byp_data_ff : ram_rd_data;
   assign s1_go = !s1_valid_ff || !flags.emit || !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !clear_ff && s1_go;
   assign accept = req_if.valid && req_if.ready;
   assign in_range = (32'(req_if.channel) < CHANNELS);

   vlendf_step #(
      .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
   ) u_step (
      .cur_entry(cur_entry),
      .in_byte  (s1_byte_ff),
      .nxt_entry(nxt_entry),
      .flags    (flags)
   );

   vlendf_ram #(
      .WIDTH(EntW),
      .DEPTH(CHANNELS)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (s1_go),
      .rd_addr(AW'(req_if.channel)),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      clear_in = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (32'(clear_addr_ff) == CHANNELS - 1) begin
            clear_in = 1'b0;
         end
      end

      ram_wr_en = clear_ff || (s1_valid_ff && s1_go);
      ram_wr_addr = clear_ff ? clear_addr_ff : s1_addr;
      ram_wr_data = clear_ff ? '0 : nxt_entry;

      s1_valid_in = s1_valid_ff;
      s1_chan_in = s1_chan_ff;
      s1_byte_in = s1_byte_ff;
      byp_valid_in = byp_valid_ff;
      byp_addr_in = byp_addr_ff;
      byp_data_in = byp_data_ff;
      if (s1_go) begin
         s1_valid_in = accept && in_range;
         s1_chan_in = req_if.channel;
         s1_byte_in = req_if.in_byte;
         byp_valid_in = s1_valid_ff;
         byp_addr_in = s1_addr;
         byp_data_in = nxt_entry;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_chan_in = rsp_chan_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in = rsp_err_ff;
      if (s1_valid_ff && s1_go && flags.emit) begin
         rsp_valid_in = 1'b1;
         rsp_chan_in = s1_chan_ff;
         rsp_byte_in = flags.error ? '0 : s1_byte_ff;
         rsp_last_in = flags.last;
         rsp_err_in = flags.error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_ff <= clear_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff <= s1_valid_in;
         byp_valid_ff <= byp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_chan_ff <= s1_chan_in;
      s1_byte_ff <= s1_byte_in;
      byp_addr_ff <= byp_addr_in;
      byp_data_ff <= byp_data_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_channel = rsp_chan_ff;
   assign rsp_if.payload_byte = rsp_byte_ff;
   assign rsp_if.frame_last = rsp_last_ff;
   assign rsp_if.header_error = rsp_err_ff;

   // The update stage only holds its request while the response register is full and stalled.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> (rsp_valid_ff && !rsp_if.ready))
      else $error("update stage stalled without a stalled response");

   // No request reaches the update stage while the memory is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (!s1_valid_ff && !byp_valid_ff))
      else $error("request in flight during the clearing pass");

   // An error response carries neither payload nor an end-of-frame mark.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_byte_ff == '0 && !rsp_last_ff))
      else $error("error response with payload fields set");

   // A response that is emitted is loaded into the output register on the next edge.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_go && flags.emit) |=> rsp_valid_ff)
      else $error("emitted response was lost");

endmodule
